### design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/lcc_pkg.sv
// package: types, constants and codes of the lamp channel controller
package lcc_pkg;

   localparam int CHANNELS_DEF = 12;
   localparam int MASK_W       = 12;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [6:0]  PCT_FULL    = 7'd100;
   // x / 100 == (x * 5243) >> 19 for every x below 16384
   localparam logic [12:0] RECIP       = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LAMP_MASK   = 3'd0,
      REG_CORNER_MASK = 3'd1,
      REG_INTENSITY   = 3'd2,
      REG_ON_RAMP     = 3'd3,
      REG_OFF_RAMP    = 3'd4,
      REG_ON_DELAY    = 3'd5,
      REG_OFF_DELAY   = 3'd6,
      REG_N_MINUS_ONE = 3'd7
   } lcc_reg_type;

   typedef enum logic [1:0] {
      PH_RUN = 2'd0,
      PH_ON  = 2'd1,
      PH_OFF = 2'd2
   } lcc_phase_type;

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_OFF  = 2'd1,
      ST_ON   = 2'd2,
      ST_ERR  = 2'd3
   } lcc_status_type;

   typedef struct packed {
      logic [7:0]        tick_time;
      logic              lamp_request;
      logic [6:0]        afs_duty;
      logic [4:0]        derate_flags;
      logic [MASK_W-1:0] stored_faults;
      logic [MASK_W-1:0] live_faults;
      logic [MASK_W-1:0] sensor_faults;
      logic              corner_fault;
   } lcc_req_type;

   typedef struct packed {
      logic              shut_valid;
      logic [MASK_W-1:0] shut_mask;
      logic              drive_valid;
      logic [MASK_W-1:0] drive_mask;
      logic [6:0]        drive_duty;
      logic              corner_valid;
      logic [6:0]        corner_duty;
      logic              status_valid;
      logic [1:0]        lamp_status;
   } lcc_rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0] lamp_mask;
      logic [MASK_W-1:0] corner_mask;
      logic [6:0]        intensity_pct;
      logic [15:0]       on_ramp;
      logic [15:0]       off_ramp;
      logic [7:0]        on_delay;
      logic [7:0]        off_delay;
      logic              n_minus_one;
   } lcc_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic rescale;
      logic commit;
      logic pass2;
   } lcc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic shared;
      logic out_free;
   } lcc_sts_type;

endpackage

### design/lcc_csr.sv
// configuration register file
module lcc_csr #(
   parameter int CHANNELS = lcc_pkg::CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lcc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lcc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lcc_pkg::lcc_cfg_type               cfg
);
   import lcc_pkg::*;

   localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((1 << CHANNELS) - 1);

   lcc_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{lamp_mask: '0, corner_mask: '0, intensity_pct: PCT_FULL,
                     on_ramp: '0, off_ramp: '0, on_delay: '0, off_delay: '0,
                     n_minus_one: 1'b0};
      end else if (csr_we) begin
         case (csr_index)
            REG_LAMP_MASK:   cfg_ff.lamp_mask     <= csr_wdata[MASK_W-1:0] & CH_MASK;
            REG_CORNER_MASK: cfg_ff.corner_mask   <= csr_wdata[MASK_W-1:0] & CH_MASK;
            REG_INTENSITY:   cfg_ff.intensity_pct <= csr_wdata[6:0];
            REG_ON_RAMP:     cfg_ff.on_ramp       <= csr_wdata;
            REG_OFF_RAMP:    cfg_ff.off_ramp      <= csr_wdata;
            REG_ON_DELAY:    cfg_ff.on_delay      <= csr_wdata[7:0];
            REG_OFF_DELAY:   cfg_ff.off_delay     <= csr_wdata[7:0];
            REG_N_MINUS_ONE: cfg_ff.n_minus_one   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/lcc_ctrl.sv
// controller state machine: sequences the shared scaling multiplier
module lcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lcc_pkg::lcc_sts_type sts,
   output lcc_pkg::lcc_cmd_type cmd
);
   import lcc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      pass2_ff, pass2_in;

   always_comb begin
      state_in  = state_ff;
      pass2_in  = pass2_ff;
      cmd       = '0;
      cmd.pass2 = pass2_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               pass2_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            // shared mode scales the target a second time
            if (sts.shared && !pass2_ff) begin
               cmd.rescale = 1'b1;
               pass2_in    = 1'b1;
               state_in    = S_MUL;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

### design/lcc_dpath.sv
// datapath: duty scaling, channel state, counters and result register
module lcc_dpath #(
   parameter int CHANNELS = lcc_pkg::CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lcc_pkg::lcc_cfg_type cfg,
   input  lcc_pkg::lcc_req_type req_data,
   input  lcc_pkg::lcc_cmd_type cmd,
   output lcc_pkg::lcc_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lcc_pkg::lcc_rsp_type rsp_data
);
   import lcc_pkg::*;

   localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((1 << CHANNELS) - 1);

   // working registers
   lcc_req_type item_ff;
   logic [6:0]  op_ff;
   logic [13:0] prod_ff;
   logic [7:0]  q_ff;
   logic [6:0]  afs_ff;

   // lamp state
   logic [6:0]        target_ff;
   logic [MASK_W-1:0] active_ff;
   lcc_phase_type     phase_ff;
   logic [7:0]        on_dly_ff, off_dly_ff;
   logic              prev_req_ff;
   logic [15:0]       on_ramp_ff, off_ramp_ff;
   lcc_status_type    status_ff;

   // result register
   logic        rsp_valid_ff;
   lcc_rsp_type rsp_data_ff;

   // next values
   logic [6:0]        target_in;
   logic [MASK_W-1:0] active_in;
   lcc_phase_type     phase_in;
   logic [7:0]        on_dly_in, off_dly_in;
   logic [15:0]       on_ramp_in, off_ramp_in;
   lcc_status_type    status_in;
   lcc_rsp_type       rsp_in;

   logic [26:0]       recip_prod;
   logic [6:0]        scaled, a_val, basic, tgt;
   logic              shared, lamp_on, skip, bad;
   logic [MASK_W-1:0] stored, live, sensor, act0, err;
   logic [8:0]        dly_sum;
   logic [16:0]       ramp_sum;

   assign shared     = (cfg.corner_mask == cfg.lamp_mask);
   assign lamp_on    = (cfg.lamp_mask != '0);
   assign recip_prod = 27'(prod_ff) * 27'(RECIP);
   assign scaled     = (q_ff > 8'(PCT_FULL)) ? PCT_FULL : q_ff[6:0];
   assign a_val      = cmd.pass2 ? afs_ff : scaled;
   assign basic      = item_ff.lamp_request ?
                       ((cfg.intensity_pct > PCT_FULL) ? PCT_FULL : cfg.intensity_pct) : 7'd0;
   assign tgt        = (a_val != 7'd0) ? a_val : basic;
   assign stored     = item_ff.stored_faults & CH_MASK;
   assign live       = item_ff.live_faults & CH_MASK;
   assign sensor     = item_ff.sensor_faults & CH_MASK;

   always_comb begin
      target_in   = target_ff;
      active_in   = active_ff;
      phase_in    = phase_ff;
      on_dly_in   = on_dly_ff;
      off_dly_in  = off_dly_ff;
      on_ramp_in  = on_ramp_ff;
      off_ramp_in = off_ramp_ff;
      status_in   = status_ff;
      rsp_in      = '0;
      skip        = 1'b0;
      bad         = 1'b0;
      act0        = active_ff;
      err         = '0;
      dly_sum     = '0;
      ramp_sum    = '0;

      if (lamp_on) begin
         target_in = tgt;
         if (shared) begin
            rsp_in.corner_valid = 1'b1;
            rsp_in.corner_duty  = scaled;
         end else begin
            // edges of the target reload channels or enter a delay phase
            if (target_ff == 7'd0 && tgt != 7'd0) begin
               act0     = cfg.lamp_mask;
               phase_in = PH_ON;
            end else if (target_ff != 7'd0 && tgt == 7'd0) begin
               phase_in = PH_OFF;
            end
            active_in = act0;
            if (tgt != 7'd0) begin
               rsp_in.shut_valid = 1'b1;
               if (item_ff.derate_flags != '0) begin
                  rsp_in.shut_mask = act0;
                  skip             = 1'b1;
               end else begin
                  err = act0 & stored;
                  if (cfg.n_minus_one && err != '0) begin
                     err = act0;
                  end
                  active_in        = act0 ^ err;
                  rsp_in.shut_mask = err;
               end
            end
            if (!skip) begin
               case (phase_in)
                  PH_ON: begin
                     dly_sum = {1'b0, on_dly_ff} + {1'b0, item_ff.tick_time};
                     on_dly_in = dly_sum[8] ? 8'hFF : dly_sum[7:0];
                     if (on_dly_in >= cfg.on_delay) begin
                        on_dly_in = '0;
                        phase_in  = PH_RUN;
                     end
                  end
                  PH_OFF: begin
                     dly_sum = {1'b0, off_dly_ff} + {1'b0, item_ff.tick_time};
                     off_dly_in = dly_sum[8] ? 8'hFF : dly_sum[7:0];
                     if (off_dly_in >= cfg.off_delay) begin
                        off_dly_in = '0;
                        phase_in   = PH_RUN;
                     end
                  end
                  default: begin
                     rsp_in.drive_valid = 1'b1;
                     rsp_in.drive_mask  = active_in;
                     rsp_in.drive_duty  = tgt;
                  end
               endcase
            end
         end

         // ramp timers gate the status report
         if (item_ff.lamp_request != prev_req_ff) begin
            on_ramp_in  = '0;
            off_ramp_in = '0;
         end else if (item_ff.lamp_request) begin
            if (on_ramp_ff < cfg.on_ramp) begin
               ramp_sum   = {1'b0, on_ramp_ff} + 17'(item_ff.tick_time);
               on_ramp_in = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
            end else begin
               if (shared) begin
                  bad = item_ff.corner_fault;
               end else begin
                  bad = (item_ff.derate_flags[4:2] != '0) ||
                        ((cfg.lamp_mask & live) != '0) ||
                        ((cfg.lamp_mask & sensor) != '0) ||
                        (active_in != cfg.lamp_mask);
               end
               rsp_in.status_valid = 1'b1;
               status_in           = bad ? ST_ERR : ST_ON;
            end
         end else begin
            if (off_ramp_ff < cfg.off_ramp) begin
               ramp_sum    = {1'b0, off_ramp_ff} + 17'(item_ff.tick_time);
               off_ramp_in = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
            end else begin
               rsp_in.status_valid = 1'b1;
               status_in           = ST_OFF;
            end
         end
      end
      rsp_in.lamp_status = status_in;
   end

   // scaling pipeline, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
         op_ff   <= req_data.afs_duty;
      end
      if (cmd.mul) begin
         prod_ff <= 14'(op_ff) * 14'(cfg.intensity_pct);
      end
      if (cmd.div) begin
         q_ff <= 8'(recip_prod >> RECIP_SHIFT);
      end
      if (cmd.rescale) begin
         afs_ff <= scaled;
         op_ff  <= tgt;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         active_ff    <= '0;
         phase_ff     <= PH_RUN;
         on_dly_ff    <= '0;
         off_dly_ff   <= '0;
         prev_req_ff  <= 1'b0;
         on_ramp_ff   <= '0;
         off_ramp_ff  <= '0;
         status_ff    <= ST_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            if (lamp_on) begin
               target_ff   <= target_in;
               active_ff   <= active_in;
               phase_ff    <= phase_in;
               on_dly_ff   <= on_dly_in;
               off_dly_ff  <= off_dly_in;
               prev_req_ff <= item_ff.lamp_request;
               on_ramp_ff  <= on_ramp_in;
               off_ramp_ff <= off_ramp_in;
               status_ff   <= status_in;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.shared   = shared;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

### design/lamp_channel_controller.sv
// top level of the lamp channel controller
//
// usage
// - req channel: one transaction per lamp tick (elapsed time, request, adaptive
//   duty, derating flags, fault masks); accepted when req_valid is high and
//   req_stall is low
// - rsp channel: exactly one result transaction per tick (shut, drive, corner
//   and status commands), held in an output register until rsp_stall is low
// - csr port: csr_we writes register csr_index with csr_wdata; write only
//   while no tick is in flight
// - sequence: each accepted tick passes the single percentage multiplier and
//   its reciprocal divide-by-100 stage once per scaled duty, twice in
//   shared-channel mode, then commits; the next tick is accepted only after
//   the commit
// - a stalled result blocks only the final commit: the next tick's scaling
//   runs while the previous result waits
// - reset: synchronous, active high; registers return to their defaults
//   (intensity 100 percent), lamp state clears, result register empties
//
module lamp_channel_controller #(
   parameter int CHANNELS = lcc_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // tick input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lcc_pkg::lcc_req_type            req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lcc_pkg::lcc_rsp_type            rsp_data,
   // configuration write port
   input  logic                            csr_we,
   input  logic [lcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lcc_pkg::*;

   lcc_cfg_type cfg;
   lcc_cmd_type cmd;
   lcc_sts_type sts;

   // configuration registers, masks limited to the channel count
   lcc_csr #(
      .CHANNELS (CHANNELS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: accept, multiply, divide, then commit or rescale
   lcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // scaling, channel bookkeeping, counters and the result register
   lcc_dpath #(
      .CHANNELS (CHANNELS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### design/lcc_checker.sv
// port-level checker of the lamp channel controller and its bind
`include "assert_macros.svh"

module lcc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lcc_pkg::lcc_rsp_type rsp_data
);
   import lcc_pkg::*;

   logic corner_out, cmds_quiet, duty_ok, drive_idle;

   assign corner_out = rsp_valid && rsp_data.corner_valid;
   assign cmds_quiet = !rsp_data.drive_valid && !rsp_data.shut_valid;
   assign duty_ok    = (rsp_data.drive_duty <= PCT_FULL) && (rsp_data.corner_duty <= PCT_FULL);
   assign drive_idle = (rsp_data.drive_mask == '0) && (rsp_data.drive_duty == '0);

   // a waiting result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // one tick is worked at a time
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // shared mode and channel drive are exclusive
   `ASSERT_IMPL(a_mode_excl, clock, reset, corner_out, cmds_quiet)

   // duties stay in percent range, idle drive fields are zero
   `ASSERT_IMPL(a_duty_range, clock, reset, rsp_valid, duty_ok)
   `ASSERT_IMPL(a_drive_idle, clock, reset, rsp_valid && !rsp_data.drive_valid, drive_idle)

endmodule

bind lamp_channel_controller lcc_checker u_lcc_checker (.*);

### bench/tb_lamp_channel_controller.sv
// testbench of the lamp channel controller: directed ticks, then random ticks
`timescale 1ns / 1ps

module tb_lamp_channel_controller;
   import lcc_pkg::*;

   // one step of the directed part: a register write or a tick,
   // optionally with a hand-written result
   typedef struct {
      bit          is_csr;
      lcc_reg_type reg_id;
      logic [15:0] value;
      lcc_req_type stim;
      bit          typed;
      lcc_rsp_type want;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lcc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lcc_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   lcc_reg_type csr_index = REG_LAMP_MASK;
   logic [15:0] csr_wdata = '0;

   // register copy, reset values
   lcc_cfg_type cfg = '{lamp_mask: '0, corner_mask: '0, intensity_pct: PCT_FULL,
                        on_ramp: '0, off_ramp: '0, on_delay: '0, off_delay: '0,
                        n_minus_one: 1'b0};

   // lamp state as the block should hold it
   int             target_duty = 0;
   logic [11:0]    live_ch = '0;
   lcc_phase_type  phase = PH_RUN;
   int             on_wait = 0;
   int             off_wait = 0;
   bit             req_held = 1'b0;
   int             on_ramp_acc = 0;
   int             off_ramp_acc = 0;
   lcc_status_type status_now = ST_NONE;

   lcc_rsp_type  pending_commands[$];
   step_row_type plan[$];
   int           error_count = 0;
   bit           idle_on = 1'b0;
   int           stall_left = 0;

   lamp_channel_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // command computation for one tick
   // ---------------------------------------------------------------------

   // percent of the intensity setting, clamped to full duty
   function automatic int pct_of(input int v);
      int r;
      r = v * cfg.intensity_pct / 100;
      return (r > 100) ? 100 : r;
   endfunction

   function automatic int sat_add(input int a, input int b, input int top);
      return (a + b > top) ? top : a + b;
   endfunction

   function automatic lcc_rsp_type compute_commands(input lcc_req_type t);
      lcc_rsp_type r;
      int          prior_duty;
      int          scaled_afs;
      int          basic;
      int          tgt;
      bit          prior_req;
      bit          shared;
      bit          skip;
      bit          bad;
      logic [11:0] err;
      r = '0;
      shared = (cfg.corner_mask == cfg.lamp_mask);
      // an absent lamp ignores the tick completely
      if (cfg.lamp_mask != '0) begin
         prior_req = req_held;
         prior_duty = target_duty;
         // adaptive duty wins, else the basic on/off request
         scaled_afs = pct_of(t.afs_duty);
         basic = t.lamp_request ? ((cfg.intensity_pct > 100) ? 100 : cfg.intensity_pct) : 0;
         tgt = (scaled_afs > 0) ? scaled_afs : basic;
         req_held = t.lamp_request;
         target_duty = tgt;

         if (shared) begin
            // shared channels: the cornering lamp gets the duty, scaled again
            r.corner_valid = 1'b1;
            r.corner_duty = 7'(pct_of(tgt));
         end else begin
            skip = 1'b0;
            if (prior_duty == 0 && tgt > 0) begin
               live_ch = cfg.lamp_mask;
               phase = PH_ON;
            end else if (prior_duty > 0 && tgt == 0) begin
               phase = PH_OFF;
            end
            if (tgt != 0) begin
               r.shut_valid = 1'b1;
               if (t.derate_flags != '0) begin
                  // derating shuts everything in use, no drive this tick
                  r.shut_mask = live_ch;
                  skip = 1'b1;
               end else begin
                  err = live_ch & t.stored_faults;
                  if (cfg.n_minus_one && err != '0)
                     err = live_ch;
                  live_ch = live_ch ^ err;
                  r.shut_mask = err;
               end
            end
            if (!skip) begin
               case (phase)
                  PH_ON: begin
                     on_wait = sat_add(on_wait, t.tick_time, 255);
                     if (on_wait >= cfg.on_delay) begin
                        on_wait = 0;
                        phase = PH_RUN;
                     end
                  end
                  PH_OFF: begin
                     off_wait = sat_add(off_wait, t.tick_time, 255);
                     if (off_wait >= cfg.off_delay) begin
                        off_wait = 0;
                        phase = PH_RUN;
                     end
                  end
                  default: begin
                     r.drive_valid = 1'b1;
                     r.drive_mask = live_ch;
                     r.drive_duty = 7'(tgt);
                  end
               endcase
            end
         end

         // status once the request has been held for its ramp time
         if (t.lamp_request != prior_req) begin
            on_ramp_acc = 0;
            off_ramp_acc = 0;
         end else if (t.lamp_request) begin
            if (on_ramp_acc < cfg.on_ramp) begin
               on_ramp_acc = sat_add(on_ramp_acc, t.tick_time, 65535);
            end else begin
               if (shared)
                  bad = t.corner_fault;
               else
                  bad = (t.derate_flags & 5'h1c) != '0 ||
                        (cfg.lamp_mask & t.live_faults) != '0 ||
                        (cfg.lamp_mask & t.sensor_faults) != '0 ||
                        live_ch != cfg.lamp_mask;
               r.status_valid = 1'b1;
               status_now = bad ? ST_ERR : ST_ON;
            end
         end else begin
            if (off_ramp_acc < cfg.off_ramp) begin
               off_ramp_acc = sat_add(off_ramp_acc, t.tick_time, 65535);
            end else begin
               r.status_valid = 1'b1;
               status_now = ST_OFF;
            end
         end
      end
      r.lamp_status = status_now;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // every result transaction is matched against the oldest pending one
   always @(posedge clock) begin : result_check
      lcc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_commands.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = pending_commands.pop_front();
            check_field("shut_valid", want.shut_valid, rsp_data.shut_valid);
            check_field("shut_mask", want.shut_mask, rsp_data.shut_mask);
            check_field("drive_valid", want.drive_valid, rsp_data.drive_valid);
            check_field("drive_mask", want.drive_mask, rsp_data.drive_mask);
            check_field("drive_duty", want.drive_duty, rsp_data.drive_duty);
            check_field("corner_valid", want.corner_valid, rsp_data.corner_valid);
            check_field("corner_duty", want.corner_duty, rsp_data.corner_duty);
            check_field("status_valid", want.status_valid, rsp_data.status_valid);
            check_field("lamp_status", want.lamp_status, rsp_data.lamp_status);
         end
      end
   end

   // result side stalls in bursts, started only while idling is on
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // called at a falling edge; returns at a falling edge
   task automatic csr_write(input lcc_reg_type id, input logic [15:0] v);
      csr_we <= 1'b1;
      csr_index <= id;
      csr_wdata <= v;
      case (id)
         REG_LAMP_MASK:   cfg.lamp_mask = v[11:0];
         REG_CORNER_MASK: cfg.corner_mask = v[11:0];
         REG_INTENSITY:   cfg.intensity_pct = v[6:0];
         REG_ON_RAMP:     cfg.on_ramp = v;
         REG_OFF_RAMP:    cfg.off_ramp = v;
         REG_ON_DELAY:    cfg.on_delay = v[7:0];
         REG_OFF_DELAY:   cfg.off_delay = v[7:0];
         default:         cfg.n_minus_one = v[0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid and let every pending result come out before a register write
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // one tick transaction: optional gap, then hold until accepted
   task automatic send_tick(input lcc_req_type t, input bit typed, input lcc_rsp_type want);
      int          gap;
      lcc_rsp_type pred;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do
         @(posedge clock);
      while (req_stall);
      // state advances on every tick, hand-written rows override the result
      pred = compute_commands(t);
      pending_commands.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   function automatic lcc_req_type tk(input int tick, input bit on, input int afs,
                                      input int derate, input int stored,
                                      input int live, input int sensor, input bit cf);
      return '{8'(tick), on, 7'(afs), 5'(derate), 12'(stored), 12'(live), 12'(sensor), cf};
   endfunction

   function automatic void add_write(input lcc_reg_type id, input logic [15:0] v);
      step_row_type row;
      row = '{is_csr: 1'b1, reg_id: id, value: v, stim: '0, typed: 1'b0, want: '0};
      plan.push_back(row);
   endfunction

   function automatic void add_tick(input lcc_req_type t, input bit typed = 1'b0,
                                    input lcc_rsp_type want = '0);
      step_row_type row;
      row = '{is_csr: 1'b0, reg_id: REG_LAMP_MASK, value: '0, stim: t, typed: typed,
              want: want};
      plan.push_back(row);
   endfunction

   // random faults are kept rare so that lamps get through their delays and ramps
   function automatic logic [11:0] rare_mask(input int odds);
      if ($urandom_range(0, odds) != 0)
         return '0;
      else if ($urandom_range(0, 1))
         return 12'(1 << $urandom_range(0, 11));
      else
         return 12'($urandom);
   endfunction

   function automatic lcc_req_type random_tick(input bit on, input bit slow);
      lcc_req_type t;
      if (slow)
         t.tick_time = 8'd255;
      else if ($urandom_range(0, 3) == 0)
         t.tick_time = 8'($urandom_range(0, 255));
      else
         t.tick_time = 8'($urandom_range(0, 40));
      t.lamp_request = on;
      t.afs_duty = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(0, 100));
      t.derate_flags = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, 31)) : 5'd0;
      t.stored_faults = rare_mask(12);
      t.live_faults = rare_mask(6);
      t.sensor_faults = rare_mask(6);
      t.corner_fault = ($urandom_range(0, 3) == 0);
      return t;
   endfunction

   // a fresh setting of every register
   task automatic random_settings();
      logic [11:0] lamp;
      logic [11:0] corner;
      lamp = ($urandom_range(0, 7) == 0) ? 12'hfff : 12'($urandom_range(1, 4095));
      case ($urandom_range(0, 5))
         0, 1:    corner = lamp;        // shared channels
         2:       corner = '0;
         default: corner = 12'($urandom);
      endcase
      csr_write(REG_LAMP_MASK, 16'(lamp));
      csr_write(REG_CORNER_MASK, 16'(corner));
      csr_write(REG_INTENSITY, $urandom_range(0, 2) == 0 ? 16'(PCT_FULL)
                                                         : 16'($urandom_range(0, 100)));
      csr_write(REG_ON_RAMP, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 800)));
      csr_write(REG_OFF_RAMP, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 800)));
      csr_write(REG_ON_DELAY, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 255)));
      csr_write(REG_OFF_DELAY, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 255)));
      csr_write(REG_N_MINUS_ONE, 16'($urandom_range(0, 1)));
   endtask

   // request held in runs, flipped now and then
   task automatic play_ticks(input int count);
      bit want_on;
      want_on = $urandom_range(0, 1);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            want_on = !want_on;
         send_tick(random_tick(want_on, 1'b0), 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      lcc_rsp_type quiet;
      quiet = '0;

      // lamp absent after reset: everything zero, status not reported
      add_tick(tk(255, 1, 100, 31, 'hfff, 'hfff, 'hfff, 1), 1'b1, quiet);
      add_write(REG_LAMP_MASK, 16'hfff);
      add_write(REG_CORNER_MASK, 16'h000);
      // switch-on: shut command with empty mask, zero on-delay ends at once
      add_tick(tk(0, 1, 0, 0, 0, 0, 0, 0), 1'b1,
               '{1'b1, 12'h000, 1'b0, 12'h000, 7'd0, 1'b0, 7'd0, 1'b0, ST_NONE});
      // full drive, zero ramp reports on
      add_tick(tk(10, 1, 0, 0, 0, 0, 0, 0), 1'b1,
               '{1'b1, 12'h000, 1'b1, 12'hfff, 7'd100, 1'b0, 7'd0, 1'b1, ST_ON});
      // live channel fault reports error
      add_tick(tk(10, 1, 0, 0, 0, 'h001, 0, 0), 1'b1,
               '{1'b1, 12'h000, 1'b1, 12'hfff, 7'd100, 1'b0, 7'd0, 1'b1, ST_ERR});
      add_tick(tk(10, 1, 0, 0, 0, 0, 'h800, 0));     // thermistor fault
      add_tick(tk(10, 1, 0, 'h01, 0, 0, 0, 0));      // supply loss derate
      add_tick(tk(10, 1, 0, 'h10, 0, 0, 0, 0));      // ambient overtemp derate
      add_tick(tk(10, 1, 0, 0, 'h003, 0, 0, 0));     // stored faults drop two channels
      add_write(REG_N_MINUS_ONE, 16'd1);
      add_tick(tk(10, 1, 0, 0, 'h010, 0, 0, 0));     // one more fault drops all
      add_tick(tk(10, 0, 0, 0, 0, 0, 0, 0));         // switch-off, zero off-delay
      // back in run: empty drive at zero duty, zero ramp reports off
      add_tick(tk(10, 0, 0, 0, 0, 0, 0, 0), 1'b1,
               '{1'b0, 12'h000, 1'b1, 12'h000, 7'd0, 1'b0, 7'd0, 1'b1, ST_OFF});
      add_write(REG_INTENSITY, 16'd37);
      add_tick(tk(20, 0, 1, 0, 0, 0, 0, 0));         // adaptive duty scales to zero
      add_tick(tk(20, 0, 100, 0, 0, 0, 0, 0));       // adaptive duty alone turns on
      add_write(REG_ON_DELAY, 16'd255);
      add_write(REG_OFF_DELAY, 16'd255);
      add_write(REG_OFF_RAMP, 16'd300);
      add_write(REG_ON_RAMP, 16'hffff);
      // longest delays and ticks, ramp counting past its limit
      add_tick(tk(255, 0, 0, 0, 0, 0, 0, 0));
      add_tick(tk(255, 0, 0, 0, 0, 0, 0, 0));
      add_tick(tk(255, 0, 0, 0, 0, 0, 0, 0));
      add_tick(tk(255, 0, 0, 0, 0, 0, 0, 0));
      add_tick(tk(255, 1, 0, 0, 0, 0, 0, 0));
      add_tick(tk(200, 1, 0, 0, 0, 0, 0, 0));
      // shared-channel mode with and without cornering fault
      add_write(REG_ON_RAMP, 16'd0);
      add_write(REG_CORNER_MASK, 16'hfff);
      add_write(REG_INTENSITY, 16'(PCT_FULL));
      add_tick(tk(5, 1, 50, 0, 0, 0, 0, 1));
      add_tick(tk(5, 1, 50, 0, 0, 0, 0, 0));
      add_tick(tk(5, 0, 100, 'h1f, 'hfff, 0, 0, 1));
      add_write(REG_INTENSITY, 16'd0);
      add_tick(tk(5, 1, 100, 0, 0, 0, 0, 0));
      add_write(REG_CORNER_MASK, 16'h000);
      add_tick(tk(5, 1, 100, 0, 0, 0, 0, 0));        // zero intensity, own channels

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_on = 1'b1;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            csr_write(plan[i].reg_id, plan[i].value);
         end else begin
            send_tick(plan[i].stim, plan[i].typed, plan[i].want);
         end
      end

      // random settings, request held in runs
      repeat (4) begin
         settle();
         random_settings();
         play_ticks(45);
      end

      // on ramp run to its top with the longest ticks, then a long off run
      settle();
      random_settings();
      csr_write(REG_CORNER_MASK, 16'h000);
      csr_write(REG_ON_RAMP, 16'hffff);
      csr_write(REG_OFF_RAMP, 16'hffff);
      repeat (259) send_tick(random_tick(1'b1, 1'b1), 1'b0, '0);
      repeat (70) send_tick(random_tick(1'b0, 1'b1), 1'b0, '0);

      // last part runs without idling on either side
      settle();
      idle_on = 1'b0;
      random_settings();
      play_ticks(60);

      settle();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
